/* rtl/tafpp_pkg.sv */
package tafpp_pkg;

  // Internal CORDIC datapath width; the front end shifts every difference left
  // by a fixed amount that puts the top bit of its magnitude field at bit 59.
  localparam int DATA_W = 64;
  localparam int FIXED_POINT_TOP = 59;

  // Angle accumulator in units of 2^-18 degree; the sum of all table
  // entries stays well below 2^26.
  localparam int ACC_W = 27;

  // Output angle in units of 1/1024 degree.
  localparam int ANGLE_W = 17;
  localparam int ROUND_SHIFT = 8;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 17'd92160;

  typedef logic signed [DATA_W-1:0] cdata_t;
  typedef logic signed [ACC_W-1:0] angle_acc_t;

  // Flags decided at the front end and carried down the pipeline.
  typedef struct packed {
    logic nearer;    // first point has the smaller depth
    logic degen;     // the two points coincide
    logic vertical;  // planar distance zero, depth difference not zero
    logic flat;      // depth difference zero
  } side_t;

  // atan(2^-i) in degrees, units of 2^-18 degree, rounded to nearest.
  function automatic angle_acc_t atan_entry(input logic [4:0] idx);
    angle_acc_t val;
    case (idx)
      5'd0:    val = 27'sd11796480;
      5'd1:    val = 27'sd6963869;
      5'd2:    val = 27'sd3679517;
      5'd3:    val = 27'sd1867780;
      5'd4:    val = 27'sd937515;
      5'd5:    val = 27'sd469214;
      5'd6:    val = 27'sd234664;
      5'd7:    val = 27'sd117339;
      5'd8:    val = 27'sd58671;
      5'd9:    val = 27'sd29335;
      5'd10:   val = 27'sd14668;
      5'd11:   val = 27'sd7334;
      5'd12:   val = 27'sd3667;
      5'd13:   val = 27'sd1833;
      5'd14:   val = 27'sd917;
      5'd15:   val = 27'sd458;
      5'd16:   val = 27'sd229;
      5'd17:   val = 27'sd115;
      5'd18:   val = 27'sd57;
      5'd19:   val = 27'sd29;
      5'd20:   val = 27'sd14;
      5'd21:   val = 27'sd7;
      5'd22:   val = 27'sd4;
      5'd23:   val = 27'sd2;
      5'd24:   val = 27'sd1;
      default: val = 27'sd0;
    endcase
    return val;
  endfunction

endpackage

/* rtl/tafpp_front.sv */
module tafpp_front #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] first_z,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] second_z,
  output logic                          v,
  output tafpp_pkg::cdata_t             px,
  output tafpp_pkg::cdata_t             py,
  output tafpp_pkg::cdata_t             pz,
  output tafpp_pkg::side_t              side
);
  import tafpp_pkg::*;

  localparam int DW   = COORD_WIDTH + 1;
  localparam int FRAC = FIXED_POINT_TOP - COORD_WIDTH;

  logic signed [DW-1:0] dx, dy, dz;
  logic [DW-1:0]        adx, ady, adz;
  logic                 planar_zero, depth_zero;
  cdata_t               px_next, py_next, pz_next;
  side_t                side_next;

  always_comb begin
    dx = {first_x[COORD_WIDTH-1], first_x} - {second_x[COORD_WIDTH-1], second_x};
    dy = {first_y[COORD_WIDTH-1], first_y} - {second_y[COORD_WIDTH-1], second_y};
    dz = {first_z[COORD_WIDTH-1], first_z} - {second_z[COORD_WIDTH-1], second_z};
    adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
    adz = dz[DW-1] ? DW'(-dz) : DW'(dz);
    px_next = $signed({{(DATA_W-DW){1'b0}}, adx}) <<< FRAC;
    py_next = $signed({{(DATA_W-DW){1'b0}}, ady}) <<< FRAC;
    pz_next = $signed({{(DATA_W-DW){1'b0}}, adz}) <<< FRAC;
    planar_zero = (dx == '0) && (dy == '0);
    depth_zero  = (dz == '0);
    side_next.nearer   = first_z < second_z;
    side_next.degen    = planar_zero && depth_zero;
    side_next.vertical = planar_zero && !depth_zero;
    side_next.flat     = depth_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px   <= px_next;
      py   <= py_next;
      pz   <= pz_next;
      side <= side_next;
    end
  end

endmodule

/* rtl/tafpp_dual_step.sv */
module tafpp_dual_step #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              v_in,
  input  tafpp_pkg::cdata_t xa_in,
  input  tafpp_pkg::cdata_t ya_in,
  input  tafpp_pkg::cdata_t xb_in,
  input  tafpp_pkg::cdata_t yb_in,
  input  tafpp_pkg::side_t  side_in,
  output logic              v,
  output tafpp_pkg::cdata_t xa,
  output tafpp_pkg::cdata_t ya,
  output tafpp_pkg::cdata_t xb,
  output tafpp_pkg::cdata_t yb,
  output tafpp_pkg::side_t  side
);
  import tafpp_pkg::*;

  cdata_t xa_next, ya_next, xb_next, yb_next;

  // Two independent vectoring rotations: the planar pair and the depth pair.
  always_comb begin
    if (!ya_in[DATA_W-1]) begin
      xa_next = xa_in + (ya_in >>> STEP);
      ya_next = ya_in - (xa_in >>> STEP);
    end else begin
      xa_next = xa_in - (ya_in >>> STEP);
      ya_next = ya_in + (xa_in >>> STEP);
    end
    if (!yb_in[DATA_W-1]) begin
      xb_next = xb_in + (yb_in >>> STEP);
      yb_next = yb_in - (xb_in >>> STEP);
    end else begin
      xb_next = xb_in - (yb_in >>> STEP);
      yb_next = yb_in + (xb_in >>> STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa   <= xa_next;
      ya   <= ya_next;
      xb   <= xb_next;
      yb   <= yb_next;
      side <= side_in;
    end
  end

endmodule

/* rtl/tafpp_angle_step.sv */
module tafpp_angle_step #(
  parameter int STEP = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  v_in,
  input  tafpp_pkg::cdata_t     x_in,
  input  tafpp_pkg::cdata_t     y_in,
  input  tafpp_pkg::angle_acc_t acc_in,
  input  tafpp_pkg::side_t      side_in,
  output logic                  v,
  output tafpp_pkg::cdata_t     x,
  output tafpp_pkg::cdata_t     y,
  output tafpp_pkg::angle_acc_t acc,
  output tafpp_pkg::side_t      side
);
  import tafpp_pkg::*;

  cdata_t     x_next, y_next;
  angle_acc_t acc_next;
  angle_acc_t step_angle;

  always_comb begin
    step_angle = atan_entry(5'(STEP));
    if (!y_in[DATA_W-1]) begin
      x_next   = x_in + (y_in >>> STEP);
      y_next   = y_in - (x_in >>> STEP);
      acc_next = acc_in + step_angle;
    end else begin
      x_next   = x_in - (y_in >>> STEP);
      y_next   = y_in + (x_in >>> STEP);
      acc_next = acc_in - step_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x    <= x_next;
      y    <= y_next;
      acc  <= acc_next;
      side <= side_in;
    end
  end

endmodule

/* rtl/tafpp_back.sv */
module tafpp_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             v_in,
  input  tafpp_pkg::angle_acc_t            acc_in,
  input  tafpp_pkg::side_t                 side_in,
  input  logic                             out_stall,
  output logic                             en,
  output logic                             out_valid,
  output logic [tafpp_pkg::ANGLE_W-1:0]    tilt_angle,
  output logic                             first_nearer,
  output logic                             degenerate
);
  import tafpp_pkg::*;

  localparam int SUM_W = ACC_W + 1;
  localparam int RND_W = SUM_W - ROUND_SHIFT;

  logic signed [SUM_W-1:0] sum;
  logic [RND_W-1:0]        rounded;
  logic [ANGLE_W-1:0]      angle_next;

  logic                    skid_valid;
  logic [ANGLE_W-1:0]      skid_angle;
  logic                    skid_nearer;
  logic                    skid_degen;
  logic                    take_new;
  logic                    to_skid;

  always_comb begin
    sum     = {acc_in[ACC_W-1], acc_in} + SUM_W'(1 << (ROUND_SHIFT - 1));
    rounded = sum[SUM_W-1:ROUND_SHIFT];
    if (side_in.degen || side_in.flat) begin
      angle_next = '0;
    end else if (side_in.vertical) begin
      angle_next = ANGLE_MAX;
    end else if (acc_in[ACC_W-1] || (acc_in == '0)) begin
      angle_next = '0;
    end else if (rounded > RND_W'(ANGLE_MAX)) begin
      angle_next = ANGLE_MAX;
    end else begin
      angle_next = rounded[ANGLE_W-1:0];
    end
  end

  // The pipeline advances whenever the skid register is empty.
  assign en       = !skid_valid;
  assign take_new = !skid_valid && v_in && (!out_valid || !out_stall);
  assign to_skid  = !skid_valid && v_in && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (take_new) begin
      out_valid <= 1'b1;
    end else if (to_skid) begin
      skid_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid && !out_stall) begin
      tilt_angle   <= skid_angle;
      first_nearer <= skid_nearer;
      degenerate   <= skid_degen;
    end else if (take_new) begin
      tilt_angle   <= angle_next;
      first_nearer <= side_in.nearer;
      degenerate   <= side_in.degen;
    end
    if (to_skid) begin
      skid_angle  <= angle_next;
      skid_nearer <= side_in.nearer;
      skid_degen  <= side_in.degen;
    end
  end

endmodule

/* rtl/tilt_angle_from_point_pair_top.sv */
// Tilt angle between two 3D points, fully pipelined.
//
// Input channel: in_valid / in_stall carry one beat per point pair, the six
// signed coordinates first_x .. second_z in 1/256 mm. A beat is taken on a
// rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry one beat per pair: tilt_angle
// (1/1024 degree, 0 to 90 degrees), first_nearer and degenerate.
//
// Throughput is one pair per clock while in_stall is low. The pair passes one
// front-end register for the differences, which loads on the edge that takes
// it, then CORDIC_STEPS stages that turn the planar and depth vectors side by
// side, CORDIC_STEPS stages that accumulate the angle, and the output register,
// which also rounds and clamps.
//
// Reset clears every valid bit, so the pipeline comes out of reset empty.
// When the receiver stalls, the result already at the output holds and the
// next finished result drops into a skid register; only then does the whole
// pipeline freeze and in_stall rise. Nothing is lost or repeated.
module tilt_angle_from_point_pair_top #(
  parameter int CORDIC_STEPS = 20,
  parameter int COORD_WIDTH  = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_WIDTH-1:0]       first_x,
  input  logic signed [COORD_WIDTH-1:0]       first_y,
  input  logic signed [COORD_WIDTH-1:0]       first_z,
  input  logic signed [COORD_WIDTH-1:0]       second_x,
  input  logic signed [COORD_WIDTH-1:0]       second_y,
  input  logic signed [COORD_WIDTH-1:0]       second_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tafpp_pkg::ANGLE_W-1:0]       tilt_angle,
  output logic                                first_nearer,
  output logic                                degenerate
);
  import tafpp_pkg::*;

  // One global advance enable; it drops only while the skid register holds
  // a beat, so there is no long ready chain through the stages.
  logic en;

  // Planar (a) and depth (b) chains; index 0 is the front-end register.
  logic       dv   [0:CORDIC_STEPS];
  cdata_t     xa   [0:CORDIC_STEPS];
  cdata_t     ya   [0:CORDIC_STEPS];
  cdata_t     xb   [0:CORDIC_STEPS];
  cdata_t     yb   [0:CORDIC_STEPS];
  side_t      dside[0:CORDIC_STEPS];

  // Angle chain, fed by the gained planar length and gained depth.
  logic       av   [0:CORDIC_STEPS];
  cdata_t     ax   [0:CORDIC_STEPS];
  cdata_t     ay   [0:CORDIC_STEPS];
  angle_acc_t aacc [0:CORDIC_STEPS];
  side_t      aside[0:CORDIC_STEPS];

  assign in_stall = !en;

  tafpp_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .first_x  (first_x),
    .first_y  (first_y),
    .first_z  (first_z),
    .second_x (second_x),
    .second_y (second_y),
    .second_z (second_z),
    .v        (dv[0]),
    .px       (xa[0]),
    .py       (ya[0]),
    .pz       (xb[0]),
    .side     (dside[0])
  );

  // The depth vector starts on the x axis.
  assign yb[0] = '0;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_dual
    tafpp_dual_step #(
      .STEP(k)
    ) u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .v_in    (dv[k]),
      .xa_in   (xa[k]),
      .ya_in   (ya[k]),
      .xb_in   (xb[k]),
      .yb_in   (yb[k]),
      .side_in (dside[k]),
      .v       (dv[k+1]),
      .xa      (xa[k+1]),
      .ya      (ya[k+1]),
      .xb      (xb[k+1]),
      .yb      (yb[k+1]),
      .side    (dside[k+1])
    );
  end

  // The residual y values of the first two rotations are not needed.
  assign av[0]    = dv[CORDIC_STEPS];
  assign ax[0]    = xa[CORDIC_STEPS];
  assign ay[0]    = xb[CORDIC_STEPS];
  assign aacc[0]  = '0;
  assign aside[0] = dside[CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_angle
    tafpp_angle_step #(
      .STEP(k)
    ) u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .v_in    (av[k]),
      .x_in    (ax[k]),
      .y_in    (ay[k]),
      .acc_in  (aacc[k]),
      .side_in (aside[k]),
      .v       (av[k+1]),
      .x       (ax[k+1]),
      .y       (ay[k+1]),
      .acc     (aacc[k+1]),
      .side    (aside[k+1])
    );
  end

  tafpp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .v_in         (av[CORDIC_STEPS]),
    .acc_in       (aacc[CORDIC_STEPS]),
    .side_in      (aside[CORDIC_STEPS]),
    .out_stall    (out_stall),
    .en           (en),
    .out_valid    (out_valid),
    .tilt_angle   (tilt_angle),
    .first_nearer (first_nearer),
    .degenerate   (degenerate)
  );

endmodule
